// ===== design/bls_pkg.sv =====
// Shared types and constants of the blitter line setup block.
`timescale 1ns / 1ps

package bls_pkg;

	// Width of the screen size registers
	localparam int unsigned DIM_BITS = 11;
	localparam int unsigned PLANE_BYTES_BITS = 18;
	localparam int unsigned ADDR_BITS = 21;
	localparam int unsigned CFG_DATA_BITS = 21;
	localparam int unsigned CFG_INDEX_BITS = 3;

	// Register map of the configuration port
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_SCREEN_WIDTH    = 3'd0,
		REG_SCREEN_HEIGHT   = 3'd1,
		REG_PLANE_BYTES     = 3'd2,
		REG_CANVAS_BASE     = 3'd3,
		REG_SCRATCH_ADDRESS = 3'd4,
		REG_OMIT_FIRST      = 3'd5
	} cfg_reg_t;

	// Reset values of the registers
	localparam logic [DIM_BITS-1:0]         RST_SCREEN_WIDTH  = 11'd320;
	localparam logic [DIM_BITS-1:0]         RST_SCREEN_HEIGHT = 11'd256;
	localparam logic [PLANE_BYTES_BITS-1:0] RST_PLANE_BYTES   = 18'd10240;
	localparam logic [ADDR_BITS-1:0]        RST_CANVAS_BASE   = 21'd0;
	localparam logic [ADDR_BITS-1:0]        RST_SCRATCH       = 21'd0;
	localparam logic                        RST_OMIT_FIRST    = 1'b1;

	// Control word fields
	localparam logic [15:0] MINTERM_XOR   = 16'h004a;
	localparam logic [15:0] CHANNELS_ACD  = 16'h0b00;
	localparam logic [15:0] CW1_SINGLE    = 16'h0002;
	localparam logic [15:0] CW1_LINE_MODE = 16'h0001;
	localparam logic [15:0] SIZE_WIDTH    = 16'h0002;

	// Octant codes: direction right/left, up/down, and whether the line is
	// steep (dy dominates) or shallow (dx dominates)
	localparam logic [2:0] OCT_RD_STEEP   = 3'd0;
	localparam logic [2:0] OCT_RU_STEEP   = 3'd1;
	localparam logic [2:0] OCT_LD_STEEP   = 3'd2;
	localparam logic [2:0] OCT_LU_STEEP   = 3'd3;
	localparam logic [2:0] OCT_RD_SHALLOW = 3'd4;
	localparam logic [2:0] OCT_LD_SHALLOW = 3'd5;
	localparam logic [2:0] OCT_RU_SHALLOW = 3'd6;
	localparam logic [2:0] OCT_LU_SHALLOW = 3'd7;

endpackage

// ===== design/blitter_line_setup_top.sv =====
// Top level of the blitter line setup block: octant, error term, moduli and addresses.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake               | Carries
// ----------+-----------+-------------------------+---------------------------------------
// input     | in        | in_valid / in_ready     | endpoints, plane index, clamp flag
// result    | out       | out_valid / out_ready   | control words, error, addresses, sizes
// config    | in        | cfg_valid / cfg_ready   | register index and write data
//
// Each item passes three register stages: the input register (_s1), the
// clamped/difference stage (_s2) and the result register (_q). One item is
// accepted per cycle while the stages are not full and stalled.
// Each stage holds when the one after it is full and stalled, and bubbles are
// squeezed out, so the block keeps accepting while a result waits until both
// earlier stages are full.
// Reset clears the stage valid bits and loads the register defaults.
// The configuration port is always ready, and each write is registered.

module blitter_line_setup_top
	import bls_pkg::*;
#(
	parameter int unsigned COORD_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [COORD_BITS-1:0]       start_x,
	input  logic [COORD_BITS-1:0]       start_y,
	input  logic [COORD_BITS-1:0]       end_x,
	input  logic [COORD_BITS-1:0]       end_y,
	input  logic [2:0]                  plane_index,
	input  logic                        clamp_coords,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [15:0]                 control_word0,
	output logic [15:0]                 control_word1,
	output logic signed [15:0]          error_init,
	output logic [31:0]                 source_address,
	output logic [31:0]                 dest_address,
	output logic signed [15:0]          mod_a,
	output logic [14:0]                 mod_b,
	output logic [7:0]                  row_bytes,
	output logic [15:0]                 size_word,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

	// Compare width for clamping, and arithmetic width for the error terms
	localparam int unsigned CW = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
	localparam int unsigned EW = (COORD_BITS + 3 > 16) ? COORD_BITS + 3 : 16;

	// Everything the second stage needs from the first
	typedef struct packed {
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
		logic [COORD_BITS-1:0] dx;
		logic [COORD_BITS-1:0] dy;
		logic                  y_ge;   // y1 >= y2: line goes up or stays level
		logic                  x_le;   // x1 <= x2
		logic                  x_ge;   // x1 >= x2
		logic [2:0]            plane;
	} line_s2_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [DIM_BITS-1:0]         screen_width_q;
	logic [DIM_BITS-1:0]         screen_height_q;
	logic [PLANE_BYTES_BITS-1:0] plane_bytes_q;
	logic [ADDR_BITS-1:0]        canvas_base_q;
	logic [ADDR_BITS-1:0]        scratch_q;
	logic                        omit_first_q;

	assign cfg_ready = 1'b1;

	// Take a write whenever it is offered; unknown indexes drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			plane_bytes_q   <= RST_PLANE_BYTES;
			canvas_base_q   <= RST_CANVAS_BASE;
			scratch_q       <= RST_SCRATCH;
			omit_first_q    <= RST_OMIT_FIRST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:    screen_width_q  <= cfg_data[DIM_BITS-1:0];
				REG_SCREEN_HEIGHT:   screen_height_q <= cfg_data[DIM_BITS-1:0];
				REG_PLANE_BYTES:     plane_bytes_q   <= cfg_data[PLANE_BYTES_BITS-1:0];
				REG_CANVAS_BASE:     canvas_base_q   <= cfg_data[ADDR_BITS-1:0];
				REG_SCRATCH_ADDRESS: scratch_q       <= cfg_data[ADDR_BITS-1:0];
				REG_OMIT_FIRST:      omit_first_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage handshake: each stage advances when the next one can take it
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, out_valid_q;
	logic ready_s1, ready_s2, ready_out;

	assign ready_out = !out_valid_q || out_ready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)  valid_s1    <= in_valid;
			if (ready_s2)  valid_s2    <= valid_s1;
			if (ready_out) out_valid_q <= valid_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic [COORD_BITS-1:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic [2:0]            plane_s1;
	logic                  clamp_s1;

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			x1_s1    <= start_x;
			y1_s1    <= start_y;
			x2_s1    <= end_x;
			y2_s1    <= end_y;
			plane_s1 <= plane_index;
			clamp_s1 <= clamp_coords;
		end
	end

	// Limit a coordinate to size-1; a zero size limits to 0
	function automatic logic [COORD_BITS-1:0] clamp_coord(
		input logic [COORD_BITS-1:0] v,
		input logic [DIM_BITS-1:0]   size
	);
		logic [CW-1:0] top;
		logic [CW-1:0] ve;
		top = (size == '0) ? '0 : CW'(size - DIM_BITS'(1));
		ve  = CW'(v);
		clamp_coord = (ve > top) ? top[COORD_BITS-1:0] : v;
	endfunction

	// Clamp, then take absolute differences and direction flags
	logic [COORD_BITS-1:0] cx1, cy1, cx2, cy2;
	line_s2_t              line_d;

	always_comb begin
		cx1 = clamp_s1 ? clamp_coord(x1_s1, screen_width_q)  : x1_s1;
		cx2 = clamp_s1 ? clamp_coord(x2_s1, screen_width_q)  : x2_s1;
		cy1 = clamp_s1 ? clamp_coord(y1_s1, screen_height_q) : y1_s1;
		cy2 = clamp_s1 ? clamp_coord(y2_s1, screen_height_q) : y2_s1;

		line_d.x1    = cx1;
		line_d.y1    = cy1;
		line_d.dx    = (cx2 >= cx1) ? cx2 - cx1 : cx1 - cx2;
		line_d.dy    = (cy2 >= cy1) ? cy2 - cy1 : cy1 - cy2;
		line_d.y_ge  = cy1 >= cy2;
		line_d.x_le  = cx1 <= cx2;
		line_d.x_ge  = cx1 >= cx2;
		line_d.plane = plane_s1;
	end

	// ------------------------------------------------------------------
	// Stage 2: clamped coordinates and differences
	// ------------------------------------------------------------------
	line_s2_t line_s2;

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			line_s2 <= line_d;
		end
	end

	// Octant, error terms, sizes and addresses
	logic                        dx_ge_dy, dx_le_dy;
	logic [2:0]                  octant;
	logic [COORD_BITS-1:0]       dmin, dmax;
	logic [EW-1:0]               dmin_e, dmax_e, dmax_p1, err_full, moda_full, modb_full;
	logic [7:0]                  pitch;
	logic [15:0]                 shift;
	logic [15:0]                 err_d;
	logic [20:0]                 plane_off;
	logic [COORD_BITS+7:0]       row_off;
	logic [COORD_BITS-4:0]       col_off;
	logic [31:0]                 addr_d;

	always_comb begin
		dx_ge_dy = line_s2.dx >= line_s2.dy;
		dx_le_dy = line_s2.dx <= line_s2.dy;

		if (line_s2.y_ge) begin
			if (line_s2.x_le) octant = dx_ge_dy ? OCT_RU_SHALLOW : OCT_RU_STEEP;
			else              octant = dx_le_dy ? OCT_LU_STEEP   : OCT_LU_SHALLOW;
		end else begin
			if (line_s2.x_ge) octant = dx_ge_dy ? OCT_LD_SHALLOW : OCT_LD_STEEP;
			else              octant = dx_le_dy ? OCT_RD_STEEP   : OCT_RD_SHALLOW;
		end

		dmin = dx_le_dy ? line_s2.dx : line_s2.dy;
		dmax = dx_le_dy ? line_s2.dy : line_s2.dx;

		// Wrap to 16 bits gives the same bits as the signed result
		dmin_e    = EW'(dmin);
		dmax_e    = EW'(dmax);
		dmax_p1   = dmax_e + EW'(1);
		err_full  = (dmin_e << 2) - (dmax_e << 1);
		moda_full = (dmin_e - dmax_e) << 2;
		modb_full = dmin_e << 2;
		err_d     = err_full[15:0];

		pitch = screen_width_q[DIM_BITS-1:3];
		shift = {line_s2.x1[3:0], 12'd0};

		plane_off = 21'(line_s2.plane) * 21'(plane_bytes_q);
		row_off   = (COORD_BITS+8)'(line_s2.y1) * (COORD_BITS+8)'(pitch);
		col_off   = {line_s2.x1[COORD_BITS-1:4], 1'b0};
		addr_d    = 32'(canvas_base_q) + 32'(plane_off) + 32'(row_off) + 32'(col_off);
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	logic [15:0] cw0_q, cw1_q, err_q, moda_q, size_q;
	logic [31:0] src_q, dst_q;
	logic [14:0] modb_q;
	logic [7:0]  pitch_q;

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_out) begin
			cw0_q   <= shift | CHANNELS_ACD | MINTERM_XOR;
			cw1_q   <= shift | {9'd0, err_d[15], 1'b0, octant, 2'b00}
			           | CW1_SINGLE | CW1_LINE_MODE;
			err_q   <= err_d;
			src_q   <= addr_d;
			dst_q   <= omit_first_q ? 32'(scratch_q) : addr_d;
			moda_q  <= moda_full[15:0];
			modb_q  <= modb_full[14:0];
			pitch_q <= pitch;
			size_q  <= {dmax_p1[9:0], 6'd0} + SIZE_WIDTH;
		end
	end

	assign out_valid      = out_valid_q;
	assign control_word0  = cw0_q;
	assign control_word1  = cw1_q;
	assign error_init     = err_q;
	assign source_address = src_q;
	assign dest_address   = dst_q;
	assign mod_a          = moda_q;
	assign mod_b          = modb_q;
	assign row_bytes      = pitch_q;
	assign size_word      = size_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------

	// A full middle stage that cannot move on keeps its item
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s2 |=> valid_s2 && $stable(line_s2))
		else $error("stage 2 item changed while stalled");

	// The sign bit in control word 1 follows the error term
	a_sign_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> cw1_q[6] == err_q[15])
		else $error("sign bit disagrees with error term");

	// Both control words carry the same start shift
	a_shift_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> cw0_q[15:12] == cw1_q[15:12])
		else $error("start shift differs between control words");

	// A waiting result item stays put until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(src_q) && $stable(cw1_q))
		else $error("result item changed while stalled");

endmodule
